// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority task queue
// Entry layout, request and status codes, and field widths.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ID_W         = 16;
  localparam int PRIO_W       = 8;
  localparam int HANDLE_W     = 16;
  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;

  // Request codes
  localparam logic [1:0] REQ_ADD       = 2'd0;
  localparam logic [1:0] REQ_REMOVE_HI = 2'd1;
  localparam logic [1:0] REQ_REMOVE_ID = 2'd2;
  localparam logic [1:0] REQ_LIST      = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // One stored task
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

// File: src/sorted_priority_task_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_task_queue_top: sorted priority task queue
// Holds up to CAPACITY tasks by descending priority, equal priorities in
// insertion order; serves add, pop-highest, remove-by-id and list requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_type, task_id, task_priority and desc_handle and
//   raise start; the transfer happens at a clock edge with start high and
//   busy low. busy stays high until every result of the request is out.
//   Results: each result is on status/out_id/out_priority/out_handle/last
//   for one cycle with out_valid high; last marks the final one. The
//   receiver cannot stall, so results must be taken as they appear.
//   The sequencer visits one memory entry per cycle through a priority
//   comparator (add) and an id comparator (remove); read data is registered.
//   Add: lower-priority entries shift up until the slot is found.
//   Pop/remove-by-id: result shown as soon as the entry is found while
//   the gap closes behind it. List: one result per cycle.
//   Immediate answers (full, empty) appear the cycle after the transfer.
//   Reset: clears the task count and the sequencer; the memory keeps no
//   reset value, and data read beyond the stored count is never used.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [ID_W-1:0]     task_id,
  input  logic [PRIO_W-1:0]   task_priority,
  input  logic [HANDLE_W-1:0] desc_handle,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [ID_W-1:0]     out_id,
  output logic [PRIO_W-1:0]   out_priority,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                last
);

  localparam int AW = $clog2(CAPACITY);

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;

  // Entry memory
  spq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Request sequencer
  spq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .task_id       (task_id),
    .task_priority (task_priority),
    .desc_handle   (desc_handle),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .out_valid     (out_valid),
    .status        (status),
    .out_id        (out_id),
    .out_priority  (out_priority),
    .out_handle    (out_handle),
    .last          (last)
  );

endmodule

// File: src/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store: task entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module spq_store
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [CAPACITY];

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/spq_seq.sv
// ----------------------------------------------------------------------------
// spq_seq: request sequencer of the sorted priority task queue
// Walks the entry memory one entry per cycle, comparing priority or id,
// to insert, delete, shift and list entries; drives the result registers.
// ----------------------------------------------------------------------------
module spq_seq
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [ID_W-1:0]     task_id,
  input  logic [PRIO_W-1:0]   task_priority,
  input  logic [HANDLE_W-1:0] desc_handle,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output entry_t              mem_wr_data,
  output logic [AW-1:0]       mem_rd_addr,
  input  entry_t              mem_rd_data,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [ID_W-1:0]     out_id,
  output logic [PRIO_W-1:0]   out_priority,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_PUT,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_LIST
  } state_t;

  state_t        state;
  logic [AW-1:0] idx;
  logic [AW-1:0] end_idx;
  logic [CW-1:0] count;
  logic          head_only;
  entry_t        new_entry;

  logic [CW-1:0] count_m1;
  logic [AW-1:0] last_idx;
  logic          prio_stop;
  logic          hit;

  assign busy     = (state != S_IDLE);
  assign count_m1 = count - CW'(1);
  assign last_idx = count_m1[AW-1:0];

  // Compare units: priority for insert, id (or the head for pop) for delete
  assign prio_stop = (mem_rd_data.prio >= new_entry.prio);
  assign hit       = head_only || (mem_rd_data.id == new_entry.id);

  // Memory address and write control
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx;
    mem_wr_data = new_entry;
    mem_rd_addr = idx + AW'(1);
    unique case (state)
      S_IDLE: begin
        mem_rd_addr = (req_type == REQ_ADD) ? last_idx : '0;
      end
      S_ADD_SCAN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx + AW'(1);
        mem_wr_data = prio_stop ? new_entry : mem_rd_data;
        mem_rd_addr = idx - AW'(1);
      end
      S_ADD_PUT: begin
        mem_wr_en = 1'b1;
      end
      S_DEL_SHIFT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx - AW'(1);
        mem_wr_data = mem_rd_data;
      end
      S_DEL_SCAN, S_LIST: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            new_entry.id     <= task_id;
            new_entry.prio   <= task_priority;
            new_entry.handle <= desc_handle;
            idx              <= '0;
            head_only        <= (req_type == REQ_REMOVE_HI);
            if (int'(count) > MAX_RESULTS) begin
              end_idx <= AW'(MAX_RESULTS - 1);
            end else begin
              end_idx <= last_idx;
            end
            if (req_type == REQ_ADD) begin
              if (count == CW'(CAPACITY)) begin
                out_valid    <= 1'b1;
                status       <= ST_FULL;
                out_id       <= task_id;
                out_priority <= task_priority;
                out_handle   <= desc_handle;
                last         <= 1'b1;
              end else if (count == '0) begin
                state <= S_ADD_PUT;
              end else begin
                idx   <= last_idx;
                state <= S_ADD_SCAN;
              end
            end else if (count == '0) begin
              // Drop the request on an empty store
              out_valid    <= 1'b1;
              status       <= ST_EMPTY;
              out_id       <= '0;
              out_priority <= '0;
              out_handle   <= '0;
              last         <= 1'b1;
            end else if (req_type == REQ_LIST) begin
              state <= S_LIST;
            end else begin
              state <= S_DEL_SCAN;
            end
          end
        end
        S_ADD_SCAN: begin
          // Shift lower-priority entries up until the slot is found
          if (prio_stop) begin
            out_valid    <= 1'b1;
            status       <= ST_OK;
            out_id       <= new_entry.id;
            out_priority <= new_entry.prio;
            out_handle   <= new_entry.handle;
            last         <= 1'b1;
            count        <= count + CW'(1);
            state        <= S_IDLE;
          end else if (idx == '0) begin
            state <= S_ADD_PUT;
          end else begin
            idx <= idx - AW'(1);
          end
        end
        S_ADD_PUT: begin
          out_valid    <= 1'b1;
          status       <= ST_OK;
          out_id       <= new_entry.id;
          out_priority <= new_entry.prio;
          out_handle   <= new_entry.handle;
          last         <= 1'b1;
          count        <= count + CW'(1);
          state        <= S_IDLE;
        end
        S_DEL_SCAN: begin
          if (hit) begin
            out_valid    <= 1'b1;
            status       <= ST_OK;
            out_id       <= mem_rd_data.id;
            out_priority <= mem_rd_data.prio;
            out_handle   <= mem_rd_data.handle;
            last         <= 1'b1;
            if (idx == last_idx) begin
              count <= count_m1;
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_DEL_SHIFT;
            end
          end else if (idx == last_idx) begin
            out_valid    <= 1'b1;
            status       <= ST_NOT_FOUND;
            out_id       <= new_entry.id;
            out_priority <= '0;
            out_handle   <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_DEL_SHIFT: begin
          // Close the gap one entry per cycle
          if (idx == last_idx) begin
            count <= count_m1;
            state <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_LIST: begin
          out_valid    <= 1'b1;
          status       <= ST_OK;
          out_id       <= mem_rd_data.id;
          out_priority <= mem_rd_data.prio;
          out_handle   <= mem_rd_data.handle;
          last         <= (idx == end_idx);
          if (idx == end_idx) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
